// ----- rtl/kwpa_pkg.sv -----
// Shared constants, codes and types of the kernel window page allocator.
// No dependencies; every other file imports this package.
package kwpa_pkg;

   localparam int KWPA_SLOT_COUNT = 1024;
   localparam int PAGE_BITS       = 12;
   localparam int ADDR_W          = 32;
   localparam int LEN_W           = 23;
   localparam int FRAME_W         = ADDR_W - PAGE_BITS;
   localparam int SLOT_W          = FRAME_W + 1;
   localparam int PAGE_CNT_W      = 12;
   localparam int CSR_W           = 32;
   localparam int CSR_IDX_W       = 2;

   localparam logic [PAGE_BITS-1:0] OFF_MASK = '1;

   localparam logic CMD_MAP   = 1'b0;
   localparam logic CMD_UNMAP = 1'b1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_EXHAUSTED = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DIRECT_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECT_BASE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_BASE  = 2'd2;

   localparam logic [CSR_W-1:0] DIRECT_LIMIT_RST = 32'h0000_0000;
   localparam logic [CSR_W-1:0] DIRECT_BASE_RST  = 32'hC000_0000;
   localparam logic [CSR_W-1:0] WINDOW_BASE_RST  = 32'h0000_0000;

   typedef struct packed {
      logic [CSR_W-1:0] direct_limit;
      logic [CSR_W-1:0] direct_base;
      logic [CSR_W-1:0] window_base;
   } kwpa_csr_type;

   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  byte_length;
   } kwpa_item_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] result_address;
      logic              status;
   } kwpa_result_type;

endpackage

// ----- rtl/kwpa_if.sv -----
// Valid/ready channel interfaces for request and response beats.
// Depends on kwpa_pkg for field widths.
interface kwpa_req_if import kwpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [ADDR_W-1:0] address;
   logic [LEN_W-1:0]  byte_length;

   modport source (output valid, output cmd, output address, output byte_length, input ready);
   modport sink (input valid, input cmd, input address, input byte_length, output ready);
endinterface

interface kwpa_rsp_if import kwpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] result_address;
   logic              status;

   modport source (output valid, output result_address, output status, input ready);
   modport sink (input valid, input result_address, input status, output ready);
endinterface

// ----- rtl/kwpa_alu.sv -----
// Shared 32-bit add/subtract unit with carry out, used by the check, direct, fill, map-result and unmap-check steps.
// Depends on kwpa_pkg.
module kwpa_alu import kwpa_pkg::*; (
   input  logic [ADDR_W-1:0] op_a,
   input  logic [ADDR_W-1:0] op_b,
   input  logic              op_sub,
   output logic [ADDR_W:0]   sum
);

   logic [ADDR_W-1:0] b_eff;

   assign b_eff = op_sub ? ~op_b : op_b;
   assign sum   = {1'b0, op_a} + {1'b0, b_eff} + (ADDR_W+1)'(op_sub);

endmodule

// ----- rtl/kwpa_engine.sv -----
// Sequencer, slot table memory and datapath of the page allocator.
// Depends on kwpa_pkg and kwpa_alu.
module kwpa_engine import kwpa_pkg::*; #(
   parameter int SLOT_COUNT = KWPA_SLOT_COUNT
) (
   input  logic            clock,
   input  logic            reset,
   input  kwpa_csr_type    csr,
   input  logic            item_start,
   input  kwpa_item_type   item,
   input  logic            rsp_free,
   output logic            item_ready,
   output kwpa_result_type result
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = (IDX_W + 1 > PAGE_CNT_W) ? IDX_W + 1 : PAGE_CNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam logic [IDX_W:0]   SLOT_END = (IDX_W+1)'(SLOT_COUNT);
   localparam logic [FRAME_W-1:0] SLOT_LIM = FRAME_W'(SLOT_COUNT);

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_CHK    = 4'd2;
   localparam logic [3:0] S_DIRECT = 4'd3;
   localparam logic [3:0] S_SCAN   = 4'd4;
   localparam logic [3:0] S_FILL   = 4'd5;
   localparam logic [3:0] S_MAPRES = 4'd6;
   localparam logic [3:0] S_UCHK   = 4'd7;
   localparam logic [3:0] S_URD    = 4'd8;
   localparam logic [3:0] S_UCLR   = 4'd9;
   localparam logic [3:0] S_RESP   = 4'd10;

   logic [3:0]            state_ff, state_in;
   kwpa_item_type         item_ff, item_in;
   logic [PAGE_CNT_W-1:0] pages_ff, pages_in;
   logic [IDX_W:0]        scan_addr_ff, scan_addr_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [IDX_W:0]        run_start_ff, run_start_in;
   logic [CNT_W-1:0]      run_len_ff, run_len_in;
   logic [IDX_W-1:0]      start_ff, start_in;
   logic [IDX_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [PAGE_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FRAME_W-1:0]    frame_ff, frame_in;
   logic [ADDR_W-1:0]     res_ff, res_in;
   logic                  status_ff, status_in;

   logic [SLOT_W-1:0]     slot_mem [SLOT_COUNT];
   logic [SLOT_W-1:0]     rd_data_ff;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa;
   logic [SLOT_W-1:0]     mem_wd;
   logic [IDX_W-1:0]      mem_ra;

   logic [ADDR_W-1:0]     alu_a, alu_b;
   logic                  alu_sub;
   logic [ADDR_W:0]       alu_sum;

   logic [PAGE_BITS-1:0]  off;
   logic [PAGE_BITS-1:0]  in_off;
   logic [PAGE_CNT_W-1:0] map_pages, unmap_pages;
   logic [CNT_W-1:0]      need, run_len_inc;
   logic [FRAME_W-1:0]    bi;

   kwpa_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_sub (alu_sub),
      .sum    (alu_sum)
   );

   assign in_off      = item.address[PAGE_BITS-1:0];
   assign map_pages   = PAGE_CNT_W'((24'(item.byte_length) + 24'(OFF_MASK)) >> PAGE_BITS);
   assign unmap_pages = PAGE_CNT_W'((24'(item.byte_length) + 24'(in_off) + 24'(OFF_MASK))
                                    >> PAGE_BITS);
   assign off         = item_ff.address[PAGE_BITS-1:0];
   assign need        = (pages_ff == '0) ? CNT_W'(1) : CNT_W'(pages_ff);
   assign run_len_inc = run_len_ff + CNT_W'(1);
   assign bi          = alu_sum[ADDR_W-1:PAGE_BITS];

   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_CHK: begin
            alu_a = item_ff.address;
            alu_b = ADDR_W'(item_ff.byte_length);
         end
         S_DIRECT: begin
            alu_a = item_ff.address;
            alu_b = csr.direct_base;
         end
         S_FILL: begin
            alu_a = ADDR_W'(frame_ff);
            alu_b = ADDR_W'(1);
         end
         S_MAPRES: begin
            alu_a = csr.window_base;
            alu_b = ADDR_W'({start_ff, off});
         end
         S_UCHK: begin
            alu_a   = item_ff.address;
            alu_b   = csr.window_base;
            alu_sub = 1'b1;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      pages_in     = pages_ff;
      scan_addr_in = scan_addr_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      run_start_in = run_start_ff;
      run_len_in   = run_len_ff;
      start_in     = start_ff;
      wr_idx_in    = wr_idx_ff;
      cnt_in       = cnt_ff;
      frame_in     = frame_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_wa       = wr_idx_ff;
      mem_wd       = '0;
      mem_ra       = scan_addr_ff[IDX_W-1:0];
      case (state_ff)
         S_CLR: begin
            mem_we = 1'b1;
            if (wr_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               wr_idx_in = wr_idx_ff + IDX_W'(1);
            end
         end
         S_IDLE: begin
            if (item_start) begin
               item_in   = item;
               pages_in  = (item.cmd == CMD_UNMAP) ? unmap_pages : map_pages;
               status_in = STATUS_OK;
               state_in  = (item.cmd == CMD_UNMAP) ? S_UCHK : S_CHK;
            end
         end
         S_CHK: begin
            if (alu_sum <= {1'b0, csr.direct_limit}) begin
               state_in = S_DIRECT;
            end else begin
               scan_addr_in = '0;
               run_start_in = '0;
               run_len_in   = '0;
               state_in     = S_SCAN;
            end
         end
         S_DIRECT: begin
            res_in   = alu_sum[ADDR_W-1:0];
            state_in = S_RESP;
         end
         S_SCAN: begin
            if (scan_addr_ff < SLOT_END) begin
               rd_vld_in    = 1'b1;
               rd_idx_in    = scan_addr_ff[IDX_W-1:0];
               scan_addr_in = scan_addr_ff + (IDX_W+1)'(1);
            end
            if (rd_vld_ff) begin
               if (rd_data_ff[SLOT_W-1]) begin
                  run_len_in   = '0;
                  run_start_in = {1'b0, rd_idx_ff} + (IDX_W+1)'(1);
                  if (rd_idx_ff == LAST_IDX) begin
                     res_in    = '0;
                     status_in = STATUS_EXHAUSTED;
                     state_in  = S_RESP;
                  end
               end else begin
                  run_len_in = run_len_inc;
                  if (run_len_inc >= need) begin
                     start_in  = run_start_ff[IDX_W-1:0];
                     wr_idx_in = run_start_ff[IDX_W-1:0];
                     frame_in  = item_ff.address[ADDR_W-1:PAGE_BITS];
                     cnt_in    = pages_ff;
                     state_in  = (pages_ff == '0) ? S_MAPRES : S_FILL;
                  end else if (rd_idx_ff == LAST_IDX) begin
                     res_in    = '0;
                     status_in = STATUS_EXHAUSTED;
                     state_in  = S_RESP;
                  end
               end
            end
         end
         S_FILL: begin
            mem_we   = 1'b1;
            mem_wd   = {1'b1, frame_ff};
            frame_in = alu_sum[FRAME_W-1:0];
            if (cnt_ff == PAGE_CNT_W'(1)) begin
               state_in = S_MAPRES;
            end else begin
               cnt_in    = cnt_ff - PAGE_CNT_W'(1);
               wr_idx_in = wr_idx_ff + IDX_W'(1);
            end
         end
         S_MAPRES: begin
            res_in   = alu_sum[ADDR_W-1:0];
            state_in = S_RESP;
         end
         S_UCHK: begin
            mem_ra = alu_sum[PAGE_BITS+IDX_W-1:PAGE_BITS];
            if (!alu_sum[ADDR_W]) begin
               res_in   = item_ff.address;
               state_in = S_RESP;
            end else if (bi >= SLOT_LIM) begin
               res_in   = ADDR_W'(off);
               state_in = S_RESP;
            end else begin
               wr_idx_in = bi[IDX_W-1:0];
               state_in  = S_URD;
            end
         end
         S_URD: begin
            res_in   = {rd_data_ff[FRAME_W-1:0], off};
            cnt_in   = pages_ff;
            state_in = (pages_ff == '0) ? S_RESP : S_UCLR;
         end
         S_UCLR: begin
            mem_we = 1'b1;
            if (cnt_ff == PAGE_CNT_W'(1) || wr_idx_ff == LAST_IDX) begin
               state_in = S_RESP;
            end else begin
               cnt_in    = cnt_ff - PAGE_CNT_W'(1);
               wr_idx_in = wr_idx_ff + IDX_W'(1);
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= slot_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         wr_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         scan_addr_ff <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_vld_ff    <= rd_vld_in;
         scan_addr_ff <= scan_addr_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      pages_ff     <= pages_in;
      rd_idx_ff    <= rd_idx_in;
      run_start_ff <= run_start_in;
      run_len_ff   <= run_len_in;
      start_ff     <= start_in;
      frame_ff     <= frame_in;
      res_ff       <= res_in;
      status_ff    <= status_in;
   end

   assign item_ready            = (state_ff == S_IDLE);
   assign result.valid          = (state_ff == S_RESP);
   assign result.result_address = res_ff;
   assign result.status         = status_ff;

endmodule

// ----- rtl/kernel_window_page_allocator_unit.sv -----
// Direct map: check the range, add the direct base. Window map: check, scan the slot
// table for a free run, fill its slots, add the window base. Unmap: check, read the
// slot, clear its pages (clipped at the table end); outside it, answer without a read.
// Scan and fill go one slot per cycle through the slot table (one read, one write
// port); one request at a time, the next taken once the result is loaded for output.
// Reset: synchronous; a clearing pass then empties the table while req_bus.ready
// stays low. CSR writes are taken at any time.
module kernel_window_page_allocator_unit import kwpa_pkg::*; #(
   parameter int SLOT_COUNT = KWPA_SLOT_COUNT
) (
   input  logic                 clock,
   input  logic                 reset,
   kwpa_req_if.sink             req_bus,
   kwpa_rsp_if.source           rsp_bus,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   kwpa_csr_type    csr_ff, csr_in;
   kwpa_item_type   item;
   kwpa_result_type result;
   logic            item_ready;
   logic            item_start;
   logic            rsp_free;
   logic            rsp_load;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic            rsp_status_ff;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DIRECT_LIMIT: csr_in.direct_limit = csr_write_data;
            CSR_DIRECT_BASE:  csr_in.direct_base  = csr_write_data;
            CSR_WINDOW_BASE:  csr_in.window_base  = csr_write_data;
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.direct_limit <= DIRECT_LIMIT_RST;
         csr_ff.direct_base  <= DIRECT_BASE_RST;
         csr_ff.window_base  <= WINDOW_BASE_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign item.cmd         = req_bus.cmd;
   assign item.address     = req_bus.address;
   assign item.byte_length = req_bus.byte_length;
   assign item_start       = req_bus.valid && item_ready;
   assign req_bus.ready    = item_ready;

   kwpa_engine #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .item_start (item_start),
      .item       (item),
      .rsp_free   (rsp_free),
      .item_ready (item_ready),
      .result     (result)
   );

   // output register for the response beat
   assign rsp_free     = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load     = result.valid && rsp_free;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_addr_ff   <= result.result_address;
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.result_address = rsp_addr_ff;
   assign rsp_bus.status         = rsp_status_ff;

endmodule

// ----- rtl/kwpa_checker.sv -----
// Port-level assertions for the page allocator, bound to the top level.
// Depends on kwpa_pkg and kernel_window_page_allocator_unit.
module kwpa_checker import kwpa_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ADDR_W-1:0] rsp_result_address,
   input logic              rsp_status
);

   // clearing pass and empty output after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or response beat right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a request is in progress");

   a_exhausted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EXHAUSTED |-> rsp_result_address == '0)
      else $error("exhausted response with nonzero address");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_address)
                                  && $stable(rsp_status))
      else $error("stalled response beat changed");

endmodule

bind kernel_window_page_allocator_unit kwpa_checker u_kwpa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_result_address (rsp_bus.result_address),
   .rsp_status         (rsp_bus.status)
);
